>>> src/mexp_pkg.sv
// mexp_pkg: shared types and constants for the modular exponentiation block
// no dependencies; used by the interfaces, controller, datapath and top level
package mexp_pkg;

   // payload width of message and power_result words
   localparam int DATA_W = 31;
   // configuration write data width (widest register)
   localparam int CSR_W = 32;
   localparam int CSR_IDX_W = 1;

   // default parameter values
   localparam int MOD_BITS_DEF = 31;
   localparam int EXP_BITS_DEF = 32;

   // bit counter of the serial modular multiplier
   localparam int CNT_W = $clog2(DATA_W + 1);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPONENT = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RED,
      ST_RED_WB,
      ST_CHECK,
      ST_MUL,
      ST_MUL_WB,
      ST_SQR_SET,
      ST_SQR,
      ST_SQR_WB,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_STEP,
      CMD_WB_BASE,
      CMD_SET_MUL,
      CMD_SET_SQR,
      CMD_WB_ACC,
      CMD_WB_SQR
   } cmd_type;

   typedef struct packed {
      logic unit_last;
      logic exp_zero;
      logic exp_bit0;
      logic exp_rest_zero;
   } status_type;

endpackage

>>> src/mexp_req_if.sv
// mexp_req_if: request channel carrying one message word
// depends on mexp_pkg for the payload width
interface mexp_req_if;
   logic                         valid;
   logic                         ready;
   logic [mexp_pkg::DATA_W-1:0]  message;

   modport source (output valid, output message, input ready);
   modport sink (input valid, input message, output ready);
endinterface

>>> src/mexp_rsp_if.sv
// mexp_rsp_if: response channel carrying one power_result word
// depends on mexp_pkg for the payload width
interface mexp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mexp_pkg::DATA_W-1:0]  power_result;

   modport source (output valid, output power_result, input ready);
   modport sink (input valid, input power_result, output ready);
endinterface

>>> src/modular_exponentiation.sv
// modular_exponentiation: top level, configuration registers and result register
// depends on mexp_pkg, mexp_req_if, mexp_rsp_if, mexp_ctrl and mexp_dp
//
//   channel   dir   payload               handshake
//   req_ch    in    message[30:0]         valid/ready
//   rsp_ch    out   power_result[30:0]    valid/ready
//   csr_*     in    index, data[31:0]     write enable only
//
// one word at a time; each word first reduces the message, then for each exponent bit up to
// the highest set one runs a square pass, preceded by a multiply pass when the bit is set;
// the highest set bit skips its square, and a zero exponent goes straight to finish
// all passes run in the one shared bit-serial modular multiplier
// synchronous active-high reset; modulus resets to 1, exponent to 0
// finish waits for a free output register; the next word enters while a result waits
module modular_exponentiation #(
   parameter int MOD_BITS = mexp_pkg::MOD_BITS_DEF,
   parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   mexp_req_if.sink                        req_ch,
   mexp_rsp_if.source                      rsp_ch,
   input  logic                            csr_wr_en,
   input  logic [mexp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mexp_pkg::CSR_W-1:0]      csr_wr_data
);

   localparam int DW = mexp_pkg::DATA_W;

   // configuration registers
   logic [MOD_BITS-1:0] mod_ff;
   logic [EXP_BITS-1:0] exp_ff;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rsp_data_ff, rsp_data_in;

   mexp_pkg::cmd_type    cmd;
   mexp_pkg::status_type status;
   logic                 fin;
   logic                 rsp_free;
   logic [DW-1:0]        result;

   // register writes, ignoring bits above the configured widths
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= MOD_BITS'(1);
         exp_ff <= '0;
      end else if (csr_wr_en) begin
         if (csr_index == mexp_pkg::CSR_MODULUS) begin
            mod_ff <= csr_wr_data[MOD_BITS-1:0];
         end
         if (csr_index == mexp_pkg::CSR_EXPONENT) begin
            exp_ff <= csr_wr_data[EXP_BITS-1:0];
         end
      end
   end

   // output register is free when empty or being emptied this cycle
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   mexp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .rsp_free  (rsp_free),
      .status    (status),
      .cmd       (cmd),
      .req_ready (req_ch.ready),
      .fin       (fin)
   );

   mexp_dp #(
      .MOD_BITS (MOD_BITS),
      .EXP_BITS (EXP_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .modulus  (mod_ff),
      .exponent (exp_ff),
      .message  (req_ch.message),
      .status   (status),
      .result   (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (fin) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.power_result = rsp_data_ff;

`ifndef SYNTHESIS
   // one word in flight: an accepted word closes the request side
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request accepted while a word is in flight");

   // a finished word never overwrites an undelivered result
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      fin |-> (!rsp_valid_ff || rsp_ch.ready))
      else $error("result register overwritten");

   // a zero modulus always yields a zero result
   a_zero_modulus: assert property (@(posedge clock) disable iff (reset)
      (fin && (mod_ff == '0)) |=> (rsp_ch.power_result == '0))
      else $error("nonzero result with zero modulus");
`endif

endmodule

>>> src/mexp_ctrl.sv
// mexp_ctrl: sequencer for reduce, multiply and square passes
// depends on mexp_pkg for state, command and status types
module mexp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  rsp_free,
   input  mexp_pkg::status_type  status,
   output mexp_pkg::cmd_type     cmd,
   output logic                  req_ready,
   output logic                  fin
);

   mexp_pkg::state_type state_ff;
   mexp_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mexp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = mexp_pkg::CMD_NONE;
      req_ready = 1'b0;
      fin       = 1'b0;
      case (state_ff)
         mexp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd      = mexp_pkg::CMD_LOAD;
               state_in = mexp_pkg::ST_RED;
            end
         end
         mexp_pkg::ST_RED: begin
            cmd = mexp_pkg::CMD_STEP;
            if (status.unit_last) begin
               state_in = mexp_pkg::ST_RED_WB;
            end
         end
         mexp_pkg::ST_RED_WB: begin
            cmd      = mexp_pkg::CMD_WB_BASE;
            state_in = mexp_pkg::ST_CHECK;
         end
         mexp_pkg::ST_CHECK: begin
            if (status.exp_zero) begin
               state_in = mexp_pkg::ST_FINISH;
            end else if (status.exp_bit0) begin
               cmd      = mexp_pkg::CMD_SET_MUL;
               state_in = mexp_pkg::ST_MUL;
            end else begin
               cmd      = mexp_pkg::CMD_SET_SQR;
               state_in = mexp_pkg::ST_SQR;
            end
         end
         mexp_pkg::ST_MUL: begin
            cmd = mexp_pkg::CMD_STEP;
            if (status.unit_last) begin
               state_in = mexp_pkg::ST_MUL_WB;
            end
         end
         mexp_pkg::ST_MUL_WB: begin
            cmd = mexp_pkg::CMD_WB_ACC;
            // no higher exponent bits: the remaining squarings are dead
            if (status.exp_rest_zero) begin
               state_in = mexp_pkg::ST_FINISH;
            end else begin
               state_in = mexp_pkg::ST_SQR_SET;
            end
         end
         mexp_pkg::ST_SQR_SET: begin
            // coming from a multiply the square still has to run
            cmd      = mexp_pkg::CMD_SET_SQR;
            state_in = mexp_pkg::ST_SQR;
         end
         mexp_pkg::ST_SQR: begin
            cmd = mexp_pkg::CMD_STEP;
            if (status.unit_last) begin
               state_in = mexp_pkg::ST_SQR_WB;
            end
         end
         mexp_pkg::ST_SQR_WB: begin
            cmd      = mexp_pkg::CMD_WB_SQR;
            state_in = mexp_pkg::ST_CHECK;
         end
         mexp_pkg::ST_FINISH: begin
            if (rsp_free) begin
               fin      = 1'b1;
               state_in = mexp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mexp_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> src/mexp_dp.sv
// mexp_dp: operand registers and bit-serial interleaved modular multiplier
// depends on mexp_pkg for command and status types; driven by mexp_ctrl
module mexp_dp #(
   parameter int MOD_BITS = mexp_pkg::MOD_BITS_DEF,
   parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  mexp_pkg::cmd_type            cmd,
   input  logic [MOD_BITS-1:0]          modulus,
   input  logic [EXP_BITS-1:0]          exponent,
   input  logic [mexp_pkg::DATA_W-1:0]  message,
   output mexp_pkg::status_type         status,
   output logic [mexp_pkg::DATA_W-1:0]  result
);

   localparam int DW = mexp_pkg::DATA_W;
   localparam int CW = mexp_pkg::CNT_W;
   localparam int MB = MOD_BITS;

   logic [MB-1:0]       base_ff, base_in;
   logic [MB-1:0]       acc_ff, acc_in;
   logic [EXP_BITS-1:0] exp_ff, exp_in;
   logic [MB-1:0]       r_ff, r_in;
   logic [MB-1:0]       a_ff, a_in;
   logic [DW-1:0]       b_ff, b_in;
   logic [CW-1:0]       cnt_ff, cnt_in;

   logic [MB:0]   m_ext;
   logic [MB:0]   t_dbl;
   logic [MB:0]   t_red;
   logic [MB-1:0] addend;
   logic [MB:0]   t_sum;
   logic [MB:0]   t_fin;

   // one step: r = (2r + bit*a) mod m, one compare-subtract per half
   always_comb begin
      m_ext  = {1'b0, modulus};
      t_dbl  = {r_ff, 1'b0};
      t_red  = (t_dbl >= m_ext) ? (t_dbl - m_ext) : t_dbl;
      addend = b_ff[DW-1] ? a_ff : '0;
      t_sum  = {1'b0, t_red[MB-1:0]} + {1'b0, addend};
      t_fin  = (t_sum >= m_ext) ? (t_sum - m_ext) : t_sum;
   end

   always_comb begin
      base_in = base_ff;
      acc_in  = acc_ff;
      exp_in  = exp_ff;
      r_in    = r_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      case (cmd)
         mexp_pkg::CMD_LOAD: begin
            // reduce the message: multiply by one, scanning all message bits
            b_in   = message;
            a_in   = MB'(1);
            r_in   = '0;
            cnt_in = CW'(DW);
            acc_in = MB'(1);
            exp_in = exponent;
         end
         mexp_pkg::CMD_STEP: begin
            r_in   = t_fin[MB-1:0];
            b_in   = b_ff << 1;
            cnt_in = cnt_ff - CW'(1);
         end
         mexp_pkg::CMD_WB_BASE: begin
            base_in = r_ff;
         end
         mexp_pkg::CMD_SET_MUL: begin
            a_in   = base_ff;
            b_in   = DW'(acc_ff) << (DW - MB);
            r_in   = '0;
            cnt_in = CW'(MB);
         end
         mexp_pkg::CMD_SET_SQR: begin
            a_in   = base_ff;
            b_in   = DW'(base_ff) << (DW - MB);
            r_in   = '0;
            cnt_in = CW'(MB);
         end
         mexp_pkg::CMD_WB_ACC: begin
            acc_in = r_ff;
         end
         mexp_pkg::CMD_WB_SQR: begin
            base_in = r_ff;
            exp_in  = exp_ff >> 1;
         end
         mexp_pkg::CMD_NONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      acc_ff  <= acc_in;
      exp_ff  <= exp_in;
      r_ff    <= r_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
   end

   always_comb begin
      status.unit_last     = (cnt_ff == CW'(1));
      status.exp_zero      = (exp_ff == '0);
      status.exp_bit0      = exp_ff[0];
      status.exp_rest_zero = ((exp_ff >> 1) == '0);
   end

   // zero modulus gives zero; otherwise the accumulator (one if never multiplied)
   assign result = (modulus == '0) ? '0 : DW'(acc_ff);

endmodule

>>> dv/tb_modular_exponentiation.sv
// tb_modular_exponentiation: self-checking testbench for the modular exponentiation block
// depends on mexp_pkg, mexp_req_if, mexp_rsp_if and modular_exponentiation from src
// predicts every power_result word in a scoreboard class and checks them in order
module tb_modular_exponentiation;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CLOCK_PERIOD  = 8;
   localparam int          RANDOM_WORDS  = 540;
   // the tail wait outlasts the slowest word, so it covers one more word
   localparam int          TAIL_CYCLES   = 2500;
   // 560 words at worst-case latency plus stalls, taken about three times over
   localparam int unsigned CYCLE_LIMIT   = 4_000_000;
   localparam int          MAX_REPORTED  = 10;
   localparam int          TX_IDLE_FIRST = 13;
   localparam int          RX_IDLE_FIRST = 69;

   // expected power_result words and the register copies they are computed from
   class power_board;
      logic [mexp_pkg::DATA_W-1:0]       expected_powers[$];
      logic [mexp_pkg::MOD_BITS_DEF-1:0] modulus_copy  = 1;
      logic [mexp_pkg::EXP_BITS_DEF-1:0] exponent_copy = 0;
      int unsigned                       failures      = 0;

      function void load_registers(logic [mexp_pkg::CSR_W-1:0] mod_word,
                                   logic [mexp_pkg::CSR_W-1:0] exp_word);
         modulus_copy  = mod_word[mexp_pkg::MOD_BITS_DEF-1:0];
         exponent_copy = exp_word[mexp_pkg::EXP_BITS_DEF-1:0];
      endfunction

      // right-to-left square and multiply on 64-bit products
      function logic [mexp_pkg::DATA_W-1:0] predict_power(logic [mexp_pkg::DATA_W-1:0] msg);
         logic [63:0] acc;
         logic [63:0] base;
         logic [63:0] m;
         m = 64'(modulus_copy);
         if (m == 0)
            return '0;
         base = 64'(msg) % m;
         acc  = 64'd1;
         for (int i = 0; i < mexp_pkg::EXP_BITS_DEF; i++) begin
            if (exponent_copy[i])
               acc = (acc * base) % m;
            base = (base * base) % m;
         end
         return acc[mexp_pkg::DATA_W-1:0];
      endfunction

      function void note_message(logic [mexp_pkg::DATA_W-1:0] msg);
         expected_powers.push_back(predict_power(msg));
      endfunction

      function void check_result(logic [mexp_pkg::DATA_W-1:0] got);
         logic [mexp_pkg::DATA_W-1:0] want;
         if (expected_powers.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTED)
               $display("error: power_result %h with no word outstanding", got);
            return;
         end
         want = expected_powers.pop_front();
         if (got !== want) begin
            failures++;
            if (failures <= MAX_REPORTED)
               $display("error: power_result expected %h actual %h", want, got);
         end
      endfunction

      function int pending();
         return expected_powers.size();
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           csr_wr_en;
   logic [mexp_pkg::CSR_IDX_W-1:0] csr_index;
   logic [mexp_pkg::CSR_W-1:0]     csr_wr_data;
   int                             tx_idle_pct = TX_IDLE_FIRST;
   int                             rx_idle_pct = RX_IDLE_FIRST;
   int unsigned                    cycle_count = 0;
   power_board                     board = new;

   mexp_req_if req_ch();
   mexp_rsp_if rsp_ch();

   modular_exponentiation DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // watchdog against a hung handshake
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL modular_exponentiation");
         $finish;
      end
   end

   // result side: check each accepted word, then pick ready for the next cycle
   // outputs are sampled right after the edge, so they still hold pre-edge values
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_result(rsp_ch.power_result);
      rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // offer one message word, with random idle cycles ahead of it
   // valid stays high afterwards so back-to-back words need no extra step
   task automatic send_word(input logic [mexp_pkg::DATA_W-1:0] msg);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.message <= msg;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      board.note_message(msg);
   endtask

   // block idle: drop valid, wait out every outstanding word
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
   endtask

   // both registers are always written, one per cycle, only while idle
   task automatic apply_config(input logic [mexp_pkg::CSR_W-1:0] mod_word,
                               input logic [mexp_pkg::CSR_W-1:0] exp_word);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_index   <= mexp_pkg::CSR_MODULUS;
      csr_wr_data <= mod_word;
      @(posedge clock);
      csr_index   <= mexp_pkg::CSR_EXPONENT;
      csr_wr_data <= exp_word;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.load_registers(mod_word, exp_word);
   endtask

   initial begin
      int                          random_sent;
      int                          burst;
      logic [mexp_pkg::CSR_W-1:0]  mod_word;
      logic [mexp_pkg::CSR_W-1:0]  exp_word;
      logic [mexp_pkg::DATA_W-1:0] msg;

      random_sent    = 0;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.message <= '0;
      csr_wr_en      <= 1'b0;
      csr_index      <= mexp_pkg::CSR_MODULUS;
      csr_wr_data    <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: widest operands, all-ones exponent
      apply_config(32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_word(31'h0000_0000);
      send_word(31'h0000_0001);
      send_word(31'h7FFF_FFFF);
      send_word(31'h7FFF_FFFE);
      send_word(31'h5555_5555);
      send_word(31'h2AAA_AAAA);
      // modulus bit 31 is ignored, only the top exponent bit set
      apply_config(32'hFFFF_FFFF, 32'h8000_0000);
      send_word(31'h1234_5678);
      send_word(31'h0000_0003);
      // zero exponent gives 1 even for a modulus of 1
      apply_config(32'h0000_0001, 32'h0000_0000);
      send_word(31'h0000_0000);
      send_word(31'h7FFF_FFFF);
      // modulus of 1 with a nonzero exponent reduces to 0
      apply_config(32'h0000_0001, 32'h0000_0005);
      send_word(31'h0000_0007);
      // zero modulus (only bit 31 written) always gives 0
      apply_config(32'h8000_0000, 32'h0000_0003);
      send_word(31'h0000_0005);
      send_word(31'h7FFF_FFFF);
      // zero modulus beats the zero exponent rule
      apply_config(32'h0000_0000, 32'h0000_0000);
      send_word(31'h0000_0009);
      apply_config(32'h0000_0002, 32'h0000_0001);
      send_word(31'h0000_0003);
      send_word(31'h0000_0002);
      // small rsa key pair, encrypt then decrypt
      apply_config(32'd3233, 32'd17);
      send_word(31'd65);
      apply_config(32'd3233, 32'd2753);
      send_word(31'd2790);
      // message above the modulus needs the initial reduction
      apply_config(32'h7FFF_FFFE, 32'h0000_0002);
      send_word(31'h7FFF_FFFF);

      // random phases: new registers, then a burst of words
      while (random_sent < RANDOM_WORDS) begin
         // receiver-heavy idling, then sender-heavy, then none
         if (random_sent < RANDOM_WORDS / 3) begin
            tx_idle_pct = TX_IDLE_FIRST;
            rx_idle_pct = RX_IDLE_FIRST;
         end else if (random_sent < 2 * RANDOM_WORDS / 3) begin
            tx_idle_pct = RX_IDLE_FIRST;
            rx_idle_pct = TX_IDLE_FIRST;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end

         // bit 31 of the modulus word is sometimes random and must be ignored
         case ($urandom_range(11))
            0:       mod_word = 32'h7FFF_FFFF | {1'($urandom_range(1)), 31'h0};
            1:       mod_word = 32'd1;
            2:       mod_word = 32'd2;
            3:       mod_word = {1'($urandom_range(1)), 31'h0};
            4, 5:    mod_word = 32'($urandom_range(255, 3));
            default: mod_word = $urandom;
         endcase

         // long exponents are slow, so most stay short
         case ($urandom_range(9))
            0:       exp_word = $urandom;
            1:       exp_word = 32'hFFFF_FFFF;
            2:       exp_word = 32'h0000_0000;
            3:       exp_word = 32'h0000_0001;
            default: exp_word = $urandom & ((32'd1 << $urandom_range(12, 2)) - 32'd1);
         endcase

         apply_config(mod_word, exp_word);
         burst = $urandom_range(30, 12);
         repeat (burst) begin
            case ($urandom_range(7))
               0:       msg = mexp_pkg::DATA_W'($urandom_range(3));
               1:       msg = mod_word[mexp_pkg::DATA_W-1:0] - 1'b1;
               2:       msg = mod_word[mexp_pkg::DATA_W-1:0]
                              + mexp_pkg::DATA_W'($urandom_range(3));
               3:       msg = 31'h7FFF_FFFF;
               default: msg = mexp_pkg::DATA_W'($urandom);
            endcase
            send_word(msg);
            random_sent++;
         end
      end

      // let everything come back, then watch for stray words
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (board.failures == 0 && board.pending() == 0)
         $display("PASS modular_exponentiation");
      else
         $display("FAIL modular_exponentiation");
      $finish;
   end

endmodule

>>> modular_exponentiation.f
src/mexp_pkg.sv
src/mexp_req_if.sv
src/mexp_rsp_if.sv
src/mexp_ctrl.sv
src/mexp_dp.sv
src/modular_exponentiation.sv
dv/tb_modular_exponentiation.sv
